/* rtl/spc_pkg.sv */
// shared types, constants and the square root digit step of the point classifier
// no dependencies

package spc_pkg;

   localparam int unsigned ID_W       = 16;
   localparam int unsigned LAYER_W    = 9;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned KIDX_W     = 15;
   localparam int unsigned NLAYERS_W  = 8;
   localparam int unsigned ROOT_W     = 10;
   localparam int unsigned REM_W      = 11;
   localparam int unsigned RAD_W      = 2 * ROOT_W;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned ADDR_W     = 3;
   localparam int unsigned REG_NUM_LAYERS = 0;

   localparam logic [KIND_W-1:0] KIND_CORNER   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EDGE     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INTERIOR = 2'd2;

   localparam logic [KIDX_W-1:0] CORNER_A = 15'd0;
   localparam logic [KIDX_W-1:0] CORNER_B = 15'd1;
   localparam logic [KIDX_W-1:0] CORNER_C = 15'd2;
   localparam logic [KIDX_W-1:0] EDGE_AB  = 15'd0;
   localparam logic [KIDX_W-1:0] EDGE_BC  = 15'd1;
   localparam logic [KIDX_W-1:0] EDGE_CA  = 15'd2;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } spc_sqrt_type;

   typedef struct packed {
      logic [ID_W-1:0] last;
      logic [ID_W-1:0] first_last_row;
   } spc_limits_type;

   // one restoring digit of the integer square root
   function automatic spc_sqrt_type sqrt_step(input spc_sqrt_type s, input logic [1:0] pair);
      logic [REM_W+1:0] acc;
      logic [REM_W+1:0] trial;
      spc_sqrt_type     r;
      acc   = {s.rem, pair};
      trial = {1'b0, s.root, 2'b01};
      if (acc >= trial) begin
         r.rem  = REM_W'(acc - trial);
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = REM_W'(acc);
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

/* rtl/spc_csr.sv */
// layer count register with its register port, and the derived layout limits
// depends on spc_pkg

module spc_csr import spc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_W-1:0]    paddr,
   input  logic [DATA_W-1:0]    pwdata,
   output logic [DATA_W-1:0]    prdata,
   output logic                 pready,
   output spc_limits_type       limits
);

   logic [NLAYERS_W-1:0] num_layers_ff, num_layers_in;
   spc_limits_type       limits_ff, limits_in;
   logic                 wr_en;
   logic [NLAYERS_W-1:0] l_clamped;
   logic [LAYER_W-1:0]   l_plus1;
   logic [LAYER_W-1:0]   l_plus2;
   logic [2*LAYER_W-1:0] prod;
   logic [ID_W-1:0]      last;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready && (paddr[ADDR_W-1] == 1'b0);

   always_comb begin
      num_layers_in = wr_en ? pwdata[NLAYERS_W-1:0] : num_layers_ff;
      l_clamped     = (pwdata[NLAYERS_W-1:0] == '0) ? NLAYERS_W'(1) : pwdata[NLAYERS_W-1:0];
      l_plus1       = LAYER_W'(l_clamped) + LAYER_W'(1);
      l_plus2       = LAYER_W'(l_clamped) + LAYER_W'(2);
      prod          = l_plus1 * l_plus2;
      last          = ID_W'(prod[2*LAYER_W-1:1] - 1'b1);
      limits_in     = limits_ff;
      if (wr_en) begin
         limits_in.last           = last;
         limits_in.first_last_row = last - ID_W'(l_clamped);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_layers_ff            <= NLAYERS_W'(1);
         limits_ff.last           <= ID_W'(2);
         limits_ff.first_last_row <= ID_W'(1);
      end else begin
         num_layers_ff <= num_layers_in;
         limits_ff     <= limits_in;
      end
   end

   assign prdata = (paddr[ADDR_W-1] == 1'b0) ? DATA_W'(num_layers_ff) : '0;
   assign limits = limits_ff;

endmodule

/* rtl/spc_root.sv */
// two pipeline stages of the integer square root of 8n+1, five digits each
// depends on spc_pkg

module spc_root import spc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [ID_W-1:0]   in_id,
   output logic              out_valid,
   output logic [ID_W-1:0]   out_id,
   output logic [ROOT_W-1:0] out_root
);

   localparam int unsigned HALF = ROOT_W / 2;

   logic [RAD_W-1:0]  rad;
   logic [RAD_W-1:0]  rad2;
   spc_sqrt_type      s1_in, s1_ff;
   spc_sqrt_type      s2_in;
   logic [ID_W-1:0]   id1_ff, id2_ff;
   logic [ROOT_W-1:0] root2_ff;
   logic              v1_ff, v2_ff;

   assign rad  = {1'b0, in_id, 3'b001};
   assign rad2 = {1'b0, id1_ff, 3'b001};

   always_comb begin
      s1_in = '0;
      for (int i = ROOT_W - 1; i >= int'(HALF); i--) begin
         s1_in = sqrt_step(s1_in, rad[2*i +: 2]);
      end
   end

   always_comb begin
      s2_in = s1_ff;
      for (int i = int'(HALF) - 1; i >= 0; i--) begin
         s2_in = sqrt_step(s2_in, rad2[2*i +: 2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff    <= s1_in;
      id1_ff   <= in_id;
      root2_ff <= s2_in.root;
      id2_ff   <= id1_ff;
   end

   assign out_valid = v2_ff;
   assign out_id    = id2_ff;
   assign out_root  = root2_ff;

endmodule

/* rtl/spc_classify.sv */
// layer and triangular base stage, then index and point class stage
// depends on spc_pkg

module spc_classify import spc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [ID_W-1:0]    in_id,
   input  logic [ROOT_W-1:0]  in_root,
   input  spc_limits_type     limits,
   output logic               out_valid,
   output logic [LAYER_W-1:0] out_layer,
   output logic [LAYER_W-1:0] out_index,
   output logic [KIND_W-1:0]  out_kind,
   output logic [KIDX_W-1:0]  out_kind_index,
   output logic               out_oor
);

   logic [ROOT_W-1:0]    root_m1;
   logic [LAYER_W-1:0]   lay_in;
   logic [ROOT_W-1:0]    lay_p1;
   logic [LAYER_W+ROOT_W-1:0] prod;
   logic [LAYER_W-1:0]   lay3_ff;
   logic [ID_W-1:0]      tri3_ff, id3_ff;
   logic                 v3_ff, v4_ff;

   logic [ID_W-1:0]      idx_full;
   logic [LAYER_W-1:0]   idx;
   logic [KIND_W-1:0]    kind_in;
   logic [KIDX_W-1:0]    kidx_in;
   logic                 oor_in;
   logic [ID_W-1:0]      interior;

   logic [LAYER_W-1:0]   layer_ff, index_ff;
   logic [KIND_W-1:0]    kind_ff;
   logic [KIDX_W-1:0]    kidx_ff;
   logic                 oor_ff;

   always_comb begin
      root_m1 = in_root - ROOT_W'(1);
      lay_in  = root_m1[ROOT_W-1:1];
      lay_p1  = ROOT_W'(lay_in) + ROOT_W'(1);
      prod    = lay_in * lay_p1;
   end

   always_comb begin
      idx_full = id3_ff - tri3_ff;
      idx      = idx_full[LAYER_W-1:0];
      interior = id3_ff - ID_W'({lay3_ff, 1'b0});
      oor_in   = 1'b0;
      kind_in  = KIND_CORNER;
      kidx_in  = CORNER_A;
      if (id3_ff > limits.last) begin
         oor_in = 1'b1;
      end else if (id3_ff == '0) begin
         kidx_in = CORNER_A;
      end else if (id3_ff == limits.last) begin
         kidx_in = CORNER_C;
      end else if (id3_ff == limits.first_last_row) begin
         kidx_in = CORNER_B;
      end else if (idx == '0) begin
         kind_in = KIND_EDGE;
         kidx_in = EDGE_AB;
      end else if (idx == lay3_ff) begin
         kind_in = KIND_EDGE;
         kidx_in = EDGE_CA;
      end else if (id3_ff > limits.first_last_row) begin
         kind_in = KIND_EDGE;
         kidx_in = EDGE_BC;
      end else begin
         kind_in = KIND_INTERIOR;
         kidx_in = interior[KIDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      lay3_ff  <= lay_in;
      tri3_ff  <= prod[ID_W:1];
      id3_ff   <= in_id;
      layer_ff <= lay3_ff;
      index_ff <= idx;
      kind_ff  <= kind_in;
      kidx_ff  <= kidx_in;
      oor_ff   <= oor_in;
   end

   assign out_valid      = v4_ff;
   assign out_layer      = layer_ff;
   assign out_index      = index_ff;
   assign out_kind       = kind_ff;
   assign out_kind_index = kidx_ff;
   assign out_oor        = oor_ff;

endmodule

/* rtl/subdivision_point_classifier.sv */
// top level of the subdivision point classifier: register port, root and class pipeline
// depends on spc_pkg, spc_csr, spc_root, spc_classify
//
//   channel   | handshake            | payload
//   ----------+----------------------+-----------------------------------------------
//   request   | start / busy         | req_point_id
//   response  | rsp_valid strobe     | rsp_layer, rsp_index_in_layer, rsp_point_kind,
//             |                      | rsp_kind_index, rsp_out_of_range
//   registers | psel/penable/pready  | paddr, pwdata, prdata (num_layers at 0)
//
// one item per clock, each result registered through the two square root stages
// and then through the layer and class stages
// busy stays low; the response is a one cycle strobe with no back-pressure
// synchronous reset clears the pipeline valid bits and sets num_layers to one

module subdivision_point_classifier import spc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [ID_W-1:0]    req_point_id,
   output logic               rsp_valid,
   output logic [LAYER_W-1:0] rsp_layer,
   output logic [LAYER_W-1:0] rsp_index_in_layer,
   output logic [KIND_W-1:0]  rsp_point_kind,
   output logic [KIDX_W-1:0]  rsp_kind_index,
   output logic               rsp_out_of_range,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   spc_limits_type    limits;
   logic              root_valid;
   logic [ID_W-1:0]   root_id;
   logic [ROOT_W-1:0] root;

   assign busy = 1'b0;

   spc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .limits  (limits)
   );

   spc_root u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_id     (req_point_id),
      .out_valid (root_valid),
      .out_id    (root_id),
      .out_root  (root)
   );

   spc_classify u_classify (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (root_valid),
      .in_id          (root_id),
      .in_root        (root),
      .limits         (limits),
      .out_valid      (rsp_valid),
      .out_layer      (rsp_layer),
      .out_index      (rsp_index_in_layer),
      .out_kind       (rsp_point_kind),
      .out_kind_index (rsp_kind_index),
      .out_oor        (rsp_out_of_range)
   );

endmodule

/* rtl/spc_checker.sv */
// port level checks of the point classifier, bound to the top level
// depends on spc_pkg and subdivision_point_classifier

module spc_checker import spc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [LAYER_W-1:0] rsp_layer,
   input logic [LAYER_W-1:0] rsp_index_in_layer,
   input logic [KIND_W-1:0]  rsp_point_kind,
   input logic [KIDX_W-1:0]  rsp_kind_index,
   input logic               rsp_out_of_range
);

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("item taken without a response four cycles later");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !reset, 4))
      else $error("response without an item taken four cycles earlier");

   a_index : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_index_in_layer <= rsp_layer)
      else $error("index beyond its layer");

   a_oor : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |->
         (rsp_point_kind == KIND_CORNER && rsp_kind_index == CORNER_A))
      else $error("out of range item with a class");

   a_small_index : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_point_kind == KIND_CORNER || rsp_point_kind == KIND_EDGE)) |->
         rsp_kind_index <= CORNER_C)
      else $error("corner or edge number too large");

endmodule

bind subdivision_point_classifier spc_checker u_spc_checker (.*);
